@@ rtl/clsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

	// Shuffle table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int WARMUP        = TABLE_ENTRIES + 8;
	localparam int CNT_W         = $clog2(WARMUP);

	// Field widths
	localparam int VAL_W  = 31;
	localparam int SEED_W = 32;
	localparam int MUL_W  = 16;
	localparam int PROD_W = VAL_W + MUL_W;
	localparam int FOLD_W = 8;

	// Generator constants: each modulus is 2^31 minus a small fold value
	localparam logic [VAL_W-1:0]  IM1   = 31'd2147483563;
	localparam logic [VAL_W-1:0]  IM2   = 31'd2147483399;
	localparam logic [VAL_W-1:0]  IMM1  = IM1 - 31'd1;
	localparam logic [MUL_W-1:0]  IA1   = 16'd40014;
	localparam logic [MUL_W-1:0]  IA2   = 16'd40692;
	localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
	localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

	localparam logic [VAL_W-1:0]  SECOND_RESET = 31'd123456789;
	localparam logic [SEED_W-1:0] SEED_RESET   = 32'hFFFF_FFFF;

	// Slot selection: value / NDIV through a reciprocal and one correction
	localparam longint NDIV_L   = 64'd1 + (64'd2147483562 / TABLE_ENTRIES);
	localparam logic [VAL_W-1:0] NDIV = VAL_W'(NDIV_L);
	localparam int RECIP_W  = 8;
	localparam int RECIP_SH = 32;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / NDIV_L);
	localparam int PD_W  = VAL_W + RECIP_W;
	localparam int Q_W   = PD_W - RECIP_SH;
	localparam int BND_W = Q_W + 1 + VAL_W;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam logic REG_SEED = 1'b0;

endpackage

`default_nettype wire

@@ rtl/clsr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface clsr_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface clsr_res_if import clsr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/clsr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/combined_lcg_shuffle_rng.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Combined congruential generator with a shuffle table. Each beat on req asks for one draw
// and yields one beat on rsp carrying a 31-bit value in 1..2147483562; the uniform variate
// is value / 2147483563, formed and clamped by the consumer. Two multiplicative generators
// (moduli 2^31-85 and 2^31-249) are advanced by a multiply followed by a fold-and-subtract
// reduction, and the first generator refills one slot of a 32-entry table held in a
// synchronous RAM; the slot is picked by the previous output. A draw runs from acceptance
// to the result register through a multiply, a reduction, a RAM read and a combine that
// writes the slot back. The next request is taken only once the block is back in idle, so
// draws do not overlap. When the first generator is zero or negative at the start of a draw
// (so after reset unless that draw restarts on a positive seed, or after a restart beat with
// a seed register at zero or below), 40 warm-up steps, each a multiply and a reduction, run
// first. The result register decouples the output: a new request is taken while a result
// still waits, and the block only holds in its last step if that register is still full.
// The seed register sits at APB byte address 0; write it only while no draw is in flight.
module combined_lcg_shuffle_rng import clsr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	clsr_req_if.sink               req,
	clsr_res_if.source             rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [SEED_W-1:0] pwdata,
	output logic      [SEED_W-1:0] prdata,
	output logic                   pready
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_MUL,
		S_INIT_RED,
		S_MUL,
		S_RED,
		S_RA,
		S_RD
	} state_t;

	// Product modulo (2^31 - c): fold the bits above bit 30 back in times c, then one
	// conditional subtract, since the folded sum always stays below twice the modulus.
	function automatic logic [VAL_W-1:0] fold_mod(input logic [PROD_W-1:0] p,
			input logic [FOLD_W-1:0] c, input logic [VAL_W-1:0] m);
		logic [VAL_W:0] hc;
		logic [VAL_W:0] s;
		hc = (VAL_W+1)'(p[PROD_W-1:VAL_W]) * (VAL_W+1)'(c);
		s  = {1'b0, p[VAL_W-1:0]} + hc;
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[VAL_W-1:0];
	endfunction

	// Starting value for a re-seed: zero becomes one, the most negative code saturates.
	function automatic logic [VAL_W-1:0] seed_mag(input logic [SEED_W-1:0] g);
		logic [SEED_W-1:0] n;
		n = ~g + SEED_W'(1);
		if (g == '0) begin
			return VAL_W'(1);
		end else if (g == {1'b1, {(SEED_W-1){1'b0}}}) begin
			return {VAL_W{1'b1}};
		end else begin
			return n[VAL_W-1:0];
		end
	endfunction

	state_t              state_q;
	logic [SEED_W-1:0]   seed_q;
	logic [SEED_W-1:0]   g1_q;      // first generator, signed
	logic [VAL_W-1:0]    g2_q;      // second generator
	logic [VAL_W-1:0]    last_q;    // previous output, picks the slot
	logic [VAL_W-1:0]    res_q;
	logic                res_valid_q;
	logic [PROD_W-1:0]   p1_q;
	logic [PROD_W-1:0]   p2_q;
	logic [PD_W-1:0]     pd_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TABLE_ENTRIES-1:0] vld_q;

	logic                req_fire;
	logic                rsp_free;
	logic                cfg_wr;
	logic [SEED_W-1:0]   g1_pick;
	logic                g1_nonpos;
	logic [VAL_W-1:0]    g1_fix;
	logic [VAL_W-1:0]    red1;
	logic [VAL_W-1:0]    red2;
	logic [Q_W-1:0]      q0;
	logic [Q_W:0]        qn;
	logic [Q_W:0]        qsel;
	logic [BND_W-1:0]    bnd;
	logic [IDX_W-1:0]    idx_nx;
	logic [VAL_W-1:0]    ram_rdata;
	logic [VAL_W-1:0]    entry;
	logic [VAL_W+1:0]    diff;
	logic [VAL_W+1:0]    diff_adj;
	logic [VAL_W-1:0]    draw_val;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [VAL_W-1:0]    ram_wdata;
	logic                init_wr;
	logic                draw_done;

	// Handshakes
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid & req.ready;
	assign rsp_free  = ~res_valid_q | rsp.ready;
	assign rsp.valid = res_valid_q;
	assign rsp.value = res_q;

	// APB: always ready, seed readable at its own address
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SEED);
	assign prdata = (paddr[2] == REG_SEED) ? seed_q : '0;

	// Restart takes the seed; a non-positive start triggers the warm-up sweep
	assign g1_pick   = req.restart ? seed_q : g1_q;
	assign g1_nonpos = g1_pick[SEED_W-1] | (g1_pick == '0);
	assign g1_fix    = seed_mag(g1_pick);

	// Reductions of the registered products
	assign red1 = fold_mod(p1_q, FOLD1, IM1);
	assign red2 = fold_mod(p2_q, FOLD2, IM2);

	// Slot index: the reciprocal estimate is low by at most one, so step it up once
	// if the next multiple of the divisor is still reached, then clamp as a guard.
	assign q0   = pd_q[PD_W-1:RECIP_SH];
	assign qn   = {1'b0, q0} + (Q_W+1)'(1);
	assign bnd  = BND_W'(qn) * BND_W'(NDIV);
	assign qsel = (BND_W'(last_q) >= bnd) ? qn : {1'b0, q0};
	assign idx_nx = (qsel >= (Q_W+1)'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES - 1)
			: qsel[IDX_W-1:0];

	// Slot contents minus second generator, wrapped into 1..IM1-1
	assign entry    = vld_q[idx_q] ? ram_rdata : '0;
	assign diff     = {2'b00, entry} - {2'b00, g2_q};
	assign diff_adj = (diff[VAL_W+1] || diff == '0) ? diff + {2'b00, IMM1} : diff;
	assign draw_val = diff_adj[VAL_W-1:0];

	// Table writes: warm-up fills from the top slot down, a draw refills its slot
	assign init_wr   = (state_q == S_INIT_RED) && (cnt_q < CNT_W'(TABLE_ENTRIES));
	assign draw_done = (state_q == S_RD) && rsp_free;
	assign ram_we    = init_wr | draw_done;
	assign ram_waddr = init_wr ? cnt_q[IDX_W-1:0] : idx_q;
	assign ram_wdata = init_wr ? red1 : g1_q[VAL_W-1:0];

	clsr_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= SEED_RESET;
			g1_q        <= '0;
			g2_q        <= SECOND_RESET;
			last_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
			p1_q        <= '0;
			p2_q        <= '0;
			pd_q        <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			vld_q       <= '0;
		end else begin
			if (cfg_wr) begin
				seed_q <= pwdata;
			end

			// Load a finished draw, else drop the result once the consumer has taken the beat
			if (draw_done) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && rsp.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (g1_nonpos) begin
							g1_q    <= {1'b0, g1_fix};
							g2_q    <= g1_fix;
							cnt_q   <= CNT_W'(WARMUP - 1);
							state_q <= S_INIT_MUL;
						end else begin
							g1_q    <= g1_pick;
							state_q <= S_MUL;
						end
					end
				end
				S_INIT_MUL: begin
					p1_q    <= PROD_W'(IA1) * PROD_W'(g1_q[VAL_W-1:0]);
					state_q <= S_INIT_RED;
				end
				S_INIT_RED: begin
					g1_q <= {1'b0, red1};
					if (init_wr) begin
						vld_q[cnt_q[IDX_W-1:0]] <= 1'b1;
					end
					if (cnt_q == '0) begin
						// Slot zero was just written: it seeds the slot selection
						last_q  <= red1;
						state_q <= S_MUL;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_INIT_MUL;
					end
				end
				S_MUL: begin
					p1_q    <= PROD_W'(IA1) * PROD_W'(g1_q[VAL_W-1:0]);
					p2_q    <= PROD_W'(IA2) * PROD_W'(g2_q);
					pd_q    <= PD_W'(last_q) * PD_W'(RECIP);
					state_q <= S_RED;
				end
				S_RED: begin
					g1_q    <= {1'b0, red1};
					g2_q    <= red2;
					idx_q   <= idx_nx;
					state_q <= S_RA;
				end
				S_RA: begin
					// Table read in flight
					state_q <= S_RD;
				end
				S_RD: begin
					// Hold here while the previous result still waits
					if (rsp_free) begin
						last_q       <= draw_val;
						res_q        <= draw_val;
						vld_q[idx_q] <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/clsr_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module clsr_chk import clsr_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic [VAL_W-1:0] rsp_value
);

	localparam logic [VAL_W-1:0] IMMM_CHECK = IMM1;

	logic       req_fire;
	logic       rsp_fire;
	logic [1:0] pend_q;

	assign req_fire = req_valid & req_ready;
	assign rsp_fire = rsp_valid & rsp_ready;

	// Draws accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, req_fire} - {1'b0, rsp_fire};
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result beat without an accepted draw");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> pend_q <= 2'd1)
		else $error("draw accepted with two already outstanding");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request taken again straight after a draw");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_value != '0) && (rsp_value <= IMMM_CHECK))
		else $error("result outside 1..IM1-1");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
		else $error("stalled result beat changed");

endmodule

bind combined_lcg_shuffle_rng clsr_chk u_clsr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import clsr_pkg::*;

	// Generator constants, kept wide so that no product or sum can overflow
	localparam longint GEN1_MOD  = 2147483563;
	localparam longint GEN2_MOD  = 2147483399;
	localparam longint GEN1_MUL  = 40014;
	localparam longint GEN2_MUL  = 40692;
	localparam longint GEN1_QUOT = 53668;
	localparam longint GEN2_QUOT = 52774;
	localparam longint GEN1_REM  = 12211;
	localparam longint GEN2_REM  = 3791;
	localparam longint GEN2_START = 123456789;
	localparam longint SAT_MAG    = 2147483647;
	localparam longint SLOT_SPAN  = 1 + (GEN1_MOD - 1) / longint'(TABLE_ENTRIES);

	localparam logic [ADDR_W-1:0] SEED_ADDR = ADDR_W'(4 * REG_SEED);
	localparam int PHASES     = 6;
	localparam int PHASE_LEN  = 250;

	// Tracks the generator state and holds the values still owed by the block
	class rng_scoreboard;
		longint seed_reg;
		longint gen_a;
		longint gen_b;
		longint prev_out;
		longint slots[TABLE_ENTRIES];
		logic [VAL_W-1:0] pending_values[$];
		int errors;
		int draws;
		int checked;
		int inits;
		int restarts;

		function new();
			seed_reg = -1;
			gen_a    = 0;
			gen_b    = GEN2_START;
			prev_out = 0;
			foreach (slots[i])
				slots[i] = 0;
			errors   = 0;
			draws    = 0;
			checked  = 0;
			inits    = 0;
			restarts = 0;
		endfunction

		function void set_seed(logic [SEED_W-1:0] v);
			seed_reg = $signed(v);
		endfunction

		function longint schrage_step(longint x, longint a, longint q, longint r, longint m);
			longint k;
			longint y;
			k = x / q;
			y = a * (x - k * q) - k * r;
			if (y < 0)
				y += m;
			return y;
		endfunction

		// Advance the model by one draw and queue the value it must produce
		function void note_draw(bit restart);
			longint slot;
			draws++;
			if (restart) begin
				gen_a = seed_reg;
				restarts++;
			end
			if (gen_a <= 0) begin
				if (gen_a == 0)
					gen_a = 1;
				else if (gen_a < -SAT_MAG)
					gen_a = SAT_MAG;
				else
					gen_a = -gen_a;
				gen_b = gen_a;
				for (int j = TABLE_ENTRIES + 7; j >= 0; j--) begin
					gen_a = schrage_step(gen_a, GEN1_MUL, GEN1_QUOT, GEN1_REM, GEN1_MOD);
					if (j < TABLE_ENTRIES)
						slots[j] = gen_a;
				end
				prev_out = slots[0];
				inits++;
			end
			gen_a = schrage_step(gen_a, GEN1_MUL, GEN1_QUOT, GEN1_REM, GEN1_MOD);
			gen_b = schrage_step(gen_b, GEN2_MUL, GEN2_QUOT, GEN2_REM, GEN2_MOD);
			slot = prev_out / SLOT_SPAN;
			if (slot < 0)
				slot = -slot;
			if (slot >= TABLE_ENTRIES)
				slot = TABLE_ENTRIES - 1;
			prev_out    = slots[slot] - gen_b;
			slots[slot] = gen_a;
			if (prev_out < 1)
				prev_out += GEN1_MOD - 1;
			pending_values.push_back(VAL_W'(prev_out));
		endfunction

		function void check_value(logic [VAL_W-1:0] got);
			logic [VAL_W-1:0] want;
			if (pending_values.size() == 0) begin
				$display("%0t: value %0d arrived with no draw outstanding", $time, got);
				errors++;
			end else begin
				want = pending_values.pop_front();
				checked++;
				if (got !== want) begin
					$display("%0t: value mismatch, expected %0d, actual %0d", $time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [SEED_W-1:0] pwdata;
	logic [SEED_W-1:0] prdata;
	logic pready;

	clsr_req_if req_bus();
	clsr_res_if rsp_bus();

	combined_lcg_shuffle_rng i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rng_scoreboard sb = new();

	// Random gaps on both sides; cleared for the closing phase
	bit idle_on = 1'b1;
	int seed_writes = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hang guard: even with a re-initialisation on every draw the run needs
	// well under a fifth of this
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Result side: check each beat as it is taken, then pick the next ready level.
	// Stalls come in short bursts so that they land on every step of a draw.
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready)
				sb.check_value(rsp_bus.value);
			if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 3) - 1;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Offer one draw request and hold it until the block takes the beat.
	// Called at a rising edge; returns at the edge of acceptance, or after a gap.
	task automatic send_draw(input bit restart);
		req_bus.valid   <= 1'b1;
		req_bus.restart <= restart;
		do
			@(posedge clk);
		while (!req_bus.ready);
		sb.note_draw(restart);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_bus.valid   <= 1'b0;
			req_bus.restart <= $urandom_range(0, 1);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// Drop the request line and hold until every owed value has come back.
	// Each draw gives a value, so an empty queue means no draw is in flight;
	// a few spare cycles let the write-back settle.
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (sb.pending_values.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the seed (setup then access), then read it straight back
	task automatic write_seed(input logic [SEED_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SEED_ADDR;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_seed(v);
		seed_writes++;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== v) begin
			$display("%0t: seed read-back mismatch, expected %0h, actual %0h", $time, v, prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Load a seed and restart on it, then run a few plain draws after it
	task automatic seeded_burst(input logic [SEED_W-1:0] v, input int count);
		wait_idle();
		write_seed(v);
		send_draw(1'b1);
		repeat (count - 1) send_draw(1'b0);
	endtask

	initial begin
		logic [SEED_W-1:0] phase_seed;
		int waited;

		// Known values on every input from time zero
		arst_n          <= 1'b0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		req_bus.valid   <= 1'b0;
		req_bus.restart <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Positive seed straight after reset: no warm-up, so the draw reads
		// the all-zero table.
		seeded_burst(32'sd2147483562, 3);
		// Most negative seed: its magnitude saturates
		seeded_burst(32'h8000_0000, 2);
		// Lowest in-range seed
		seeded_burst(-32'sd2147483647, 2);
		// Zero seed: warm-up starts from 1
		seeded_burst(32'd0, 2);
		// Seed equal to the first modulus: the first generator lands on zero,
		// so the following plain draw must warm up again
		seeded_burst(32'sd2147483563, 3);
		// Largest positive seed, above the modulus
		seeded_burst(32'h7FFF_FFFF, 2);
		seeded_burst(32'd1, 1);
		seeded_burst(32'hFFFF_FFFF, 2);

		// Random part: one seed per phase, the extremes among them. Each phase
		// starts from an idle block, which is also where the sender waits out
		// every outstanding value. Restarts are sprinkled through each phase.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: phase_seed = $urandom();
				1: phase_seed = $urandom_range(2147483562, 1);
				2: phase_seed = SEED_W'(-longint'($urandom_range(2147483647, 1)));
				3: phase_seed = 32'h8000_0000;
				4: phase_seed = 32'h7FFF_FFFF;
				default: phase_seed = $urandom();
			endcase
			wait_idle();
			write_seed(phase_seed);
			if (p == PHASES - 1)
				idle_on = 1'b0;
			for (int n = 0; n < PHASE_LEN; n++)
				send_draw(n == 0 || $urandom_range(0, 11) == 0);
		end
		req_bus.valid <= 1'b0;

		// Drain, with a bound, then give any late value time to arrive
		waited = 0;
		while (sb.pending_values.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);

		if (sb.pending_values.size() != 0) begin
			$display("%0t: %0d expected values never arrived, next expected %0d",
				$time, sb.pending_values.size(), sb.pending_values[0]);
			sb.errors++;
		end

		$display("Checked %0d of %0d draws over %0d seed writes (%0d restarts).",
			sb.checked, sb.draws, seed_writes, sb.restarts);
		$display("Table warm-ups predicted: %0d; mismatches: %0d.", sb.inits, sb.errors);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ combined_lcg_shuffle_rng.f @@
rtl/clsr_pkg.sv
rtl/clsr_if.sv
rtl/clsr_ram.sv
rtl/combined_lcg_shuffle_rng.sv
rtl/clsr_chk.sv
sim/tb_top.sv
